@@ rtl/core/ttg_pkg.sv @@
// Shared types, codes and constants for the trapezoidal trajectory generator.
// Used by ttg_isqrt and trapezoidal_trajectory_generator; depends on nothing.
`default_nettype none

package ttg_pkg;

  // Control tick rate; one tick is 1/TicksPerSecond s.
  localparam int unsigned TicksPerSecond = 1000;
  // Remainder width of the serial divide by the tick rate.
  localparam int DivRemW = $clog2(TicksPerSecond) + 1;

  // Serial steps per multiply or divide pass (33-bit operand).
  localparam int SerialSteps = 33;
  localparam int CntW = $clog2(SerialSteps);

  // Square root: one result bit per cycle over a 64-bit radicand.
  localparam int SqrtSteps = 32;
  localparam int SqrtCntW = $clog2(SqrtSteps);

  localparam logic [32:0] PosBand   = 33'd655;   // 0.01 rad
  localparam logic [31:0] SpeedBand = 32'd6554;  // 0.1 rad/s
  localparam logic [30:0] LimitReset = 31'd655360;  // 10.0 rad/s^2

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_RAMP,
    ST_STEP,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    ACT_STEP  = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_HOME  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_GOAL_SPEED = 3'd1,
    REG_GOAL_ANGLE = 3'd2,
    REG_ACCEL      = 3'd3,
    REG_DECEL      = 3'd4
  } cfg_reg_t;

  // Start request and completion flag of the square root unit.
  typedef struct packed {
    logic start;
    logic done;
  } sqrt_ctl_t;

  // Saturate a wide signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ttg_isqrt.sv @@
// Bit-serial integer square root, one root bit per cycle.
// Depends on ttg_pkg for widths and the control struct.
`default_nettype none

module ttg_isqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [63:0]        radicand,
  output ttg_pkg::sqrt_ctl_t      ctl,
  output logic [31:0]             root
);

  logic [63:0]                   x_r, x_nxt;
  logic [34:0]                   rem_r, rem_nxt;
  logic [31:0]                   root_r, root_nxt;
  logic [ttg_pkg::SqrtCntW-1:0]  cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [34:0]                   rem_shift;
  logic [34:0]                   trial;

  always_comb begin
    rem_shift = {rem_r[32:0], x_r[63:62]};
    trial     = {1'b0, root_r, 2'b01};
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      x_nxt   = {x_r[61:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (rem_shift >= trial) begin
        rem_nxt  = rem_shift - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_shift;
        root_nxt = {root_r[30:0], 1'b0};
      end
      if (cnt_r == ttg_pkg::SqrtCntW'(ttg_pkg::SqrtSteps - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl  = {start, done_r};
  assign root = root_r;

endmodule

`default_nettype wire

@@ rtl/core/trapezoidal_trajectory_generator.sv @@
// Trapezoidal trajectory generator top level: registers, serial multiply and
// divide datapath, ramp and integration. Depends on ttg_pkg and ttg_isqrt.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+-----------------------------------
//  in_      | input     | in_valid / in_ready   | in_tick_action
//  out_     | output    | out_valid / out_ready | out_profile_speed, out_profile_angle,
//           |           |                       | out_locked
//  cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick is processed at a time. Hold, clear and home go straight to the
// finish step. A step runs two shift-add multiplies side by side with the
// serial divide of the acceleration limit, then ramp and finish; in position
// mode a bit-serial square root follows the multiplies, and a serial divide
// of the new speed by the tick rate follows the ramp, before the finish.
// Reset is synchronous and active low; it restores the register defaults and
// clears speed and angle. A stalled output holds the finished result in the
// output register while the next tick is already being accepted; the finish
// step of that next tick waits until the output register is free.
`default_nettype none

module trapezoidal_trajectory_generator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_tick_action,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_profile_speed,
  output logic signed [31:0]      out_profile_angle,
  output logic                    out_locked,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int RW = ttg_pkg::DivRemW;
  localparam int CW = ttg_pkg::CntW;

  // Configuration registers.
  logic               mode_r;
  logic signed [31:0] goal_speed_r;
  logic signed [31:0] goal_angle_r;
  logic [30:0]        accel_r;
  logic [30:0]        decel_r;

  // Trajectory state.
  logic signed [31:0] speed_r, speed_nxt;
  logic signed [31:0] angle_r, angle_nxt;

  ttg_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  ttg_pkg::action_t   act_r, act_nxt;

  // Working registers of one tick.
  logic [32:0]        aerr_r, aerr_nxt;
  logic               up_r, up_nxt;
  logic [64:0]        p1_r, p1_nxt;
  logic [64:0]        mc1_r, mc1_nxt;
  logic [32:0]        mp1_r, mp1_nxt;
  logic [62:0]        p2_r, p2_nxt;
  logic [62:0]        mc2_r, mc2_nxt;
  logic [31:0]        mp2_r, mp2_nxt;
  logic [32:0]        div_num_r, div_num_nxt;
  logic [RW-1:0]      div_rem_r, div_rem_nxt;
  logic [32:0]        div_quo_r, div_quo_nxt;
  logic [30:0]        maxdv_r, maxdv_nxt;
  logic signed [31:0] nspeed_r, nspeed_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_speed_r, out_speed_nxt;
  logic signed [31:0] out_angle_r, out_angle_nxt;
  logic               out_locked_r, out_locked_nxt;

  // Square root unit.
  ttg_pkg::sqrt_ctl_t sqrt_ctl;
  logic               sqrt_start;
  logic [31:0]        sqrt_root;

  // Combinational helpers.
  logic signed [32:0] err;
  logic [32:0]        err_abs;
  logic [31:0]        vmag;
  logic [64:0]        p1_step;
  logic [62:0]        p2_step;
  logic [RW-1:0]      div_trial;
  logic               div_ge;
  logic [RW-1:0]      div_rem_step;
  logic [32:0]        div_quo_step;
  logic [31:0]        gs_mag;
  logic [31:0]        mag;
  logic signed [33:0] aim;
  logic signed [34:0] dv;
  logic signed [34:0] maxdv_s;
  logic signed [35:0] ramp_sum;
  logic [31:0]        nspeed_abs;
  logic signed [33:0] astep;
  logic signed [35:0] angle_sum;
  logic signed [31:0] nangle;
  logic               snap;
  logic               out_free;

  ttg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (p1_step[63:0]),
    .ctl      (sqrt_ctl),
    .root     (sqrt_root)
  );

  assign cfg_ready = 1'b1;

  // Register writes; a zero limit is ignored so decel never reaches zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      goal_speed_r <= '0;
      goal_angle_r <= '0;
      accel_r      <= ttg_pkg::LimitReset;
      decel_r      <= ttg_pkg::LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttg_pkg::REG_MODE:       mode_r       <= cfg_data[0];
        ttg_pkg::REG_GOAL_SPEED: goal_speed_r <= cfg_data;
        ttg_pkg::REG_GOAL_ANGLE: goal_angle_r <= cfg_data;
        ttg_pkg::REG_ACCEL: begin
          if (cfg_data[30:0] != 31'd0) accel_r <= cfg_data[30:0];
        end
        ttg_pkg::REG_DECEL: begin
          if (cfg_data[30:0] != 31'd0) decel_r <= cfg_data[30:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    // Position error before the update and speed magnitude.
    err     = {goal_angle_r[31], goal_angle_r} - {angle_r[31], angle_r};
    err_abs = err[32] ? 33'(-err) : err;
    vmag    = speed_r[31] ? 32'(-speed_r) : speed_r;

    // Shift-add multiply steps: decel*2*|err| and speed squared.
    p1_step = mp1_r[0] ? p1_r + mc1_r : p1_r;
    p2_step = mp2_r[0] ? p2_r + mc2_r : p2_r;

    // Restoring divide by the tick rate, one quotient bit per cycle.
    div_trial    = {div_rem_r[RW-2:0], div_num_r[32]};
    div_ge       = div_trial >= RW'(ttg_pkg::TicksPerSecond);
    div_rem_step = div_ge ? div_trial - RW'(ttg_pkg::TicksPerSecond) : div_trial;
    div_quo_step = {div_quo_r[31:0], div_ge};

    // Aim speed. Braking applies when |err| <= v^2/(2*decel), which is the
    // same as v^2 >= 2*decel*|err| exactly.
    gs_mag = goal_speed_r[31] ? 32'(-goal_speed_r) : goal_speed_r;
    mag    = ({2'b00, p2_r} < p1_r) ? gs_mag : sqrt_root;
    if (mode_r) begin
      aim = up_r ? $signed({2'b00, mag}) : -$signed({2'b00, mag});
    end else begin
      aim = {{2{goal_speed_r[31]}}, goal_speed_r};
    end
    dv      = {aim[33], aim} - {{3{speed_r[31]}}, speed_r};
    maxdv_s = $signed({4'b0000, maxdv_r});
    if (dv > maxdv_s) begin
      dv = maxdv_s;
    end else if (dv < -maxdv_s) begin
      dv = -maxdv_s;
    end
    ramp_sum = {dv[34], dv} + {{4{speed_r[31]}}, speed_r};

    // Angle integration with the rounded speed step.
    nspeed_abs = nspeed_r[31] ? 32'(-nspeed_r) : nspeed_r;
    astep      = nspeed_r[31] ? -$signed({1'b0, div_quo_r}) : $signed({1'b0, div_quo_r});
    angle_sum  = {{4{angle_r[31]}}, angle_r} + {{2{astep[33]}}, astep};
    nangle     = ttg_pkg::sat32(angle_sum);
    snap       = (aerr_r < ttg_pkg::PosBand) && (nspeed_abs < ttg_pkg::SpeedBand);

    out_free = !out_valid_r || out_ready;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    act_nxt        = act_r;
    speed_nxt      = speed_r;
    angle_nxt      = angle_r;
    aerr_nxt       = aerr_r;
    up_nxt         = up_r;
    p1_nxt         = p1_r;
    mc1_nxt        = mc1_r;
    mp1_nxt        = mp1_r;
    p2_nxt         = p2_r;
    mc2_nxt        = mc2_r;
    mp2_nxt        = mp2_r;
    div_num_nxt    = div_num_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    maxdv_nxt      = maxdv_r;
    nspeed_nxt     = nspeed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_speed_nxt  = out_speed_r;
    out_angle_nxt  = out_angle_r;
    out_locked_nxt = out_locked_r;
    sqrt_start     = 1'b0;
    in_ready       = (state_r == ttg_pkg::ST_IDLE);

    case (state_r)
      ttg_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt = ttg_pkg::action_t'(in_tick_action);
          if (ttg_pkg::action_t'(in_tick_action) == ttg_pkg::ACT_STEP) begin
            aerr_nxt    = err_abs;
            up_nxt      = !err[32];
            p1_nxt      = '0;
            mc1_nxt     = {33'd0, decel_r, 1'b0};
            mp1_nxt     = err_abs;
            p2_nxt      = '0;
            mc2_nxt     = {31'd0, vmag};
            mp2_nxt     = vmag;
            div_num_nxt = {2'b00, accel_r};
            div_rem_nxt = '0;
            div_quo_nxt = '0;
            cnt_nxt     = '0;
            state_nxt   = ttg_pkg::ST_MUL;
          end else begin
            state_nxt = ttg_pkg::ST_FIN;
          end
        end
      end
      ttg_pkg::ST_MUL: begin
        p1_nxt      = p1_step;
        mc1_nxt     = {mc1_r[63:0], 1'b0};
        mp1_nxt     = {1'b0, mp1_r[32:1]};
        p2_nxt      = p2_step;
        mc2_nxt     = {mc2_r[61:0], 1'b0};
        mp2_nxt     = {1'b0, mp2_r[31:1]};
        div_num_nxt = {div_num_r[31:0], 1'b0};
        div_rem_nxt = div_rem_step;
        div_quo_nxt = div_quo_step;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(ttg_pkg::SerialSteps - 1)) begin
          maxdv_nxt = div_quo_step[30:0];
          if (mode_r) begin
            sqrt_start = 1'b1;
            state_nxt  = ttg_pkg::ST_SQRT;
          end else begin
            state_nxt = ttg_pkg::ST_RAMP;
          end
        end
      end
      ttg_pkg::ST_SQRT: begin
        if (sqrt_ctl.done) state_nxt = ttg_pkg::ST_RAMP;
      end
      ttg_pkg::ST_RAMP: begin
        nspeed_nxt = ttg_pkg::sat32(ramp_sum);
        // Load |v| + T/2 for the rounded divide by the tick rate.
        div_num_nxt = {1'b0, (ramp_sum[35] ? 32'(-ttg_pkg::sat32(ramp_sum))
                                            : 32'(ttg_pkg::sat32(ramp_sum)))}
                      + 33'(ttg_pkg::TicksPerSecond / 2);
        div_rem_nxt = '0;
        div_quo_nxt = '0;
        cnt_nxt     = '0;
        state_nxt   = mode_r ? ttg_pkg::ST_STEP : ttg_pkg::ST_FIN;
      end
      ttg_pkg::ST_STEP: begin
        div_num_nxt = {div_num_r[31:0], 1'b0};
        div_rem_nxt = div_rem_step;
        div_quo_nxt = div_quo_step;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(ttg_pkg::SerialSteps - 1)) state_nxt = ttg_pkg::ST_FIN;
      end
      ttg_pkg::ST_FIN: begin
        if (out_free) begin
          out_locked_nxt = 1'b0;
          case (act_r)
            ttg_pkg::ACT_STEP: begin
              if (!mode_r) begin
                speed_nxt = nspeed_r;
              end else if (snap) begin
                speed_nxt      = '0;
                angle_nxt      = goal_angle_r;
                out_locked_nxt = 1'b1;
              end else begin
                speed_nxt = nspeed_r;
                angle_nxt = nangle;
              end
            end
            ttg_pkg::ACT_CLEAR: speed_nxt = '0;
            ttg_pkg::ACT_HOME: begin
              speed_nxt = '0;
              angle_nxt = '0;
            end
            default: ;
          endcase
          out_speed_nxt = speed_nxt;
          out_angle_nxt = angle_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ttg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ttg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    aerr_r       <= aerr_nxt;
    up_r         <= up_nxt;
    p1_r         <= p1_nxt;
    mc1_r        <= mc1_nxt;
    mp1_r        <= mp1_nxt;
    p2_r         <= p2_nxt;
    mc2_r        <= mc2_nxt;
    mp2_r        <= mp2_nxt;
    div_num_r    <= div_num_nxt;
    div_rem_r    <= div_rem_nxt;
    div_quo_r    <= div_quo_nxt;
    maxdv_r      <= maxdv_nxt;
    nspeed_r     <= nspeed_nxt;
    cnt_r        <= cnt_nxt;
    act_r        <= act_nxt;
    out_speed_r  <= out_speed_nxt;
    out_angle_r  <= out_angle_nxt;
    out_locked_r <= out_locked_nxt;
    if (!rst_n) begin
      state_r     <= ttg_pkg::ST_IDLE;
      speed_r     <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      angle_r     <= angle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_profile_speed = out_speed_r;
  assign out_profile_angle = out_angle_r;
  assign out_locked        = out_locked_r;

  // A locked result always carries zero speed.
  a_lock_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_locked_r |-> out_speed_r == 32'sd0)
    else $error("locked result with nonzero speed");

  // The square root only finishes while the sequencer waits for it.
  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_ctl.done |-> state_r == ttg_pkg::ST_SQRT)
    else $error("square root finished outside its wait state");

  // Serial step counter never runs past its last step.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttg_pkg::ST_MUL || state_r == ttg_pkg::ST_STEP)
      |-> cnt_r <= CW'(ttg_pkg::SerialSteps - 1))
    else $error("serial step counter out of range");

  // The braking divisor can never become zero.
  a_decel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> decel_r != 31'd0)
    else $error("deceleration limit is zero");

endmodule

`default_nettype wire

@@ dv/ttg_checker.sv @@
// Scoreboard for the trapezoidal trajectory generator: predicts every tick
// from its own copy of the registers and state, and compares the results.
// Depends on ttg_pkg for the action and register codes and the constants.
`timescale 1ns / 100ps

module ttg_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_tick_action,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_profile_speed,
  input  logic signed [31:0] out_profile_angle,
  input  logic               out_locked,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors
);

  typedef struct {
    logic signed [31:0] speed;
    logic signed [31:0] angle;
    logic               locked;
  } profile_t;

  profile_t pending_profiles[$];

  bit              pos_mode;
  longint          goal_spd, goal_ang;
  longint unsigned accel_lim, decel_lim;
  longint          trk_speed, trk_angle;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Move the speed toward the aim by at most one tick's worth of acceleration.
  function automatic longint ramp_toward(longint aim);
    longint maxdv, dv;
    maxdv = longint'(accel_lim / ttg_pkg::TicksPerSecond);
    dv = aim - trk_speed;
    if (dv > maxdv) dv = maxdv;
    else if (dv < -maxdv) dv = -maxdv;
    return clamp_s32(trk_speed + dv);
  endfunction

  function automatic profile_t advance_tick(ttg_pkg::action_t act);
    profile_t p;
    longint err, q, aim;
    longint unsigned aerr, vmag, stop_dist, mag;
    bit up;
    p.locked = 1'b0;
    case (act)
      ttg_pkg::ACT_CLEAR: trk_speed = 0;
      ttg_pkg::ACT_HOME: begin
        trk_speed = 0;
        trk_angle = 0;
      end
      ttg_pkg::ACT_STEP: begin
        if (pos_mode) begin
          err = goal_ang - trk_angle;
          up = (err >= 0);
          aerr = longint'(abs64(err));
          vmag = longint'(abs64(trk_speed));
          stop_dist = (vmag * vmag) / (2 * decel_lim);
          if (aerr > stop_dist) mag = abs64(goal_spd);
          else mag = floor_sqrt(2 * decel_lim * aerr);
          aim = up ? longint'(mag) : -longint'(mag);
          trk_speed = ramp_toward(aim);
          // Angle step rounds to nearest, ties away from zero.
          q = (abs64(trk_speed) + ttg_pkg::TicksPerSecond / 2) / ttg_pkg::TicksPerSecond;
          trk_angle = clamp_s32(trk_angle + ((trk_speed < 0) ? -q : q));
          if (aerr < ttg_pkg::PosBand && abs64(trk_speed) < ttg_pkg::SpeedBand) begin
            trk_speed = 0;
            trk_angle = goal_ang;
            p.locked = 1'b1;
          end
        end else begin
          trk_speed = ramp_toward(goal_spd);
        end
      end
      default: ;
    endcase
    p.speed = trk_speed[31:0];
    p.angle = trk_angle[31:0];
    return p;
  endfunction

  always @(posedge clk) begin
    profile_t want;
    if (!rst_n) begin
      pos_mode  <= 1'b0;
      goal_spd  = 0;
      goal_ang  = 0;
      accel_lim = ttg_pkg::LimitReset;
      decel_lim = ttg_pkg::LimitReset;
      trk_speed = 0;
      trk_angle = 0;
      pending_profiles.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ttg_pkg::cfg_reg_t'(cfg_index))
          ttg_pkg::REG_MODE:       pos_mode <= cfg_data[0];
          ttg_pkg::REG_GOAL_SPEED: goal_spd = longint'(signed'(cfg_data));
          ttg_pkg::REG_GOAL_ANGLE: goal_ang = longint'(signed'(cfg_data));
          ttg_pkg::REG_ACCEL:      if (cfg_data[30:0] != 0) accel_lim = cfg_data[30:0];
          ttg_pkg::REG_DECEL:      if (cfg_data[30:0] != 0) decel_lim = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_profiles.push_back(advance_tick(ttg_pkg::action_t'(in_tick_action)));
      if (out_valid && out_ready) begin
        if (pending_profiles.size() == 0) begin
          if (errors < 10) $display("%0t: result transfer with nothing expected", $realtime);
          errors <= errors + 1;
        end else begin
          want = pending_profiles.pop_front();
          if (want.speed !== out_profile_speed || want.angle !== out_profile_angle ||
              want.locked !== out_locked) begin
            if (errors < 10)
              $display("%0t: mismatch exp speed %0d angle %0d locked %0b, got %0d %0d %0b",
                       $realtime, want.speed, want.angle, want.locked,
                       out_profile_speed, out_profile_angle, out_locked);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Leftover expectations are judged by the top once traffic has drained.
  function automatic int outstanding();
    return pending_profiles.size();
  endfunction

endmodule

@@ dv/tb_top.sv @@
// Top of the trapezoidal trajectory generator bench: clock, reset, stimulus
// and verdict. Depends on ttg_pkg, the RTL top and ttg_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int TickTarget = 1550;
  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_tick_action = ttg_pkg::ACT_HOLD;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = ttg_pkg::REG_MODE;
  logic [31:0] cfg_data = '0;
  logic in_ready, out_valid, out_locked, cfg_ready;
  logic signed [31:0] out_profile_speed, out_profile_angle;
  int errors;

  int cycles = 0;
  int ticks_sent = 0;
  int ticks_back = 0;
  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;

  always #4 clk = ~clk;

  trapezoidal_trajectory_generator dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_tick_action, .out_valid, .out_ready,
    .out_profile_speed, .out_profile_angle, .out_locked, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  ttg_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_tick_action, .out_valid, .out_ready,
    .out_profile_speed, .out_profile_angle, .out_locked, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .errors
  );

  // Cycle count, result count and the watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) ticks_back <= ticks_back + 1;
    if (cycles > CycleLimit) begin
      $display("** trapezoidal_trajectory_generator: FAILED **");
      $finish;
    end
  end

  // Receiver. Around cycle 4000 it refuses results for a long stretch so
  // the block fills up and has to stall its input side.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (cycles == 4000) hold_left = 600;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  // Drop valid for a random gap now and then between transfers.
  task automatic maybe_idle();
    int gap;
    if (!steady && $urandom_range(99) < 34) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick(ttg_pkg::action_t act);
    maybe_idle();
    @(negedge clk);
    in_valid <= 1'b1;
    in_tick_action <= act;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every tick sent so far has come back, so the block is idle.
  task automatic drain();
    drop_valid();
    while (ticks_back != ticks_sent) @(posedge clk);
  endtask

  task automatic write_reg(ttg_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly steps, with the other actions sprinkled in.
  function automatic ttg_pkg::action_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 85) return ttg_pkg::ACT_STEP;
    if (r < 91) return ttg_pkg::ACT_HOLD;
    if (r < 96) return ttg_pkg::ACT_CLEAR;
    return ttg_pkg::ACT_HOME;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'd1;
      2: return $urandom();
      default: return $urandom_range(3276800, 131072000);
    endcase
  endfunction

  initial begin
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Speed mode at extreme goals; a zero limit write must be ignored.
    write_reg(ttg_pkg::REG_GOAL_SPEED, 32'h7FFF_FFFF);
    write_reg(ttg_pkg::REG_ACCEL, 32'h8000_0000);
    send_tick(ttg_pkg::ACT_STEP);
    send_tick(ttg_pkg::ACT_STEP);
    send_tick(ttg_pkg::ACT_HOLD);
    send_tick(ttg_pkg::ACT_CLEAR);
    send_tick(ttg_pkg::ACT_STEP);
    send_tick(ttg_pkg::ACT_HOME);
    drain();
    write_reg(ttg_pkg::REG_GOAL_SPEED, 32'h8000_0000);
    write_reg(ttg_pkg::REG_DECEL, 32'h0);
    write_reg(ttg_pkg::cfg_reg_t'(3'd5), 32'hFFFF_FFFF);
    write_reg(ttg_pkg::cfg_reg_t'(3'd7), 32'h1234_5678);
    repeat (3) send_tick(ttg_pkg::ACT_STEP);
    drain();

    // Position mode with a nearby goal and a large acceleration, so the
    // profile reaches the braking curve and brakes toward the goal.
    write_reg(ttg_pkg::REG_MODE, 32'hFFFF_FFFF);
    write_reg(ttg_pkg::REG_GOAL_ANGLE, 32'd1000);
    write_reg(ttg_pkg::REG_GOAL_SPEED, 32'd655360);
    write_reg(ttg_pkg::REG_ACCEL, 32'h7FFF_FFFF);
    repeat (8) send_tick(ttg_pkg::ACT_STEP);
    send_tick(ttg_pkg::ACT_HOLD);
    drain();

    // Full-scale run: the aim is 2^31, so the speed ramps at maximum
    // acceleration until it meets the braking curve of the far goal.
    write_reg(ttg_pkg::REG_GOAL_SPEED, 32'h8000_0000);
    write_reg(ttg_pkg::REG_GOAL_ANGLE, 32'h7FFF_FFFF);
    write_reg(ttg_pkg::REG_DECEL, 32'h7FFF_FFFF);
    for (int i = 0; i < 1060; i++) send_tick(ttg_pkg::ACT_STEP);
    send_tick(ttg_pkg::ACT_HOME);
    drain();

    // Random phases: fresh settings, then a burst of ticks.
    while (ticks_sent < TickTarget) begin
      if ($urandom_range(1)) write_reg(ttg_pkg::REG_MODE, $urandom());
      if ($urandom_range(3) == 0)
        write_reg(ttg_pkg::REG_GOAL_SPEED, $urandom());
      else
        write_reg(ttg_pkg::REG_GOAL_SPEED, $urandom_range(1310720) - 655360);
      if ($urandom_range(3) == 0)
        write_reg(ttg_pkg::REG_GOAL_ANGLE, $urandom());
      else
        write_reg(ttg_pkg::REG_GOAL_ANGLE, $urandom_range(400000) - 200000);
      write_reg(ttg_pkg::REG_ACCEL, pick_limit());
      write_reg(ttg_pkg::REG_DECEL, pick_limit());
      if ($urandom_range(9) == 0)
        write_reg(ttg_pkg::cfg_reg_t'(3'($urandom_range(5, 7))), $urandom());
      n = $urandom_range(20, 80);
      steady = (ticks_sent > 1250 && ticks_sent < 1400);
      for (int i = 0; i < n; i++) send_tick(pick_action());
      drain();
    end
    steady = 1'b0;

    repeat (150) @(posedge clk);
    if (errors == 0 && u_checker.outstanding() == 0) begin
      $display("** trapezoidal_trajectory_generator: PASSED **");
    end else begin
      $display("** trapezoidal_trajectory_generator: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ttg_pkg.sv
rtl/core/ttg_isqrt.sv
rtl/core/trapezoidal_trajectory_generator.sv
dv/ttg_checker.sv
dv/tb_top.sv
